[rtl/core/u8d_pkg.sv]
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 to UTF-16 decoder: payload
// widths, code unit constants and the queued result record.
// ----------------------------------------------------------------------------
package u8d_pkg;

    // payload widths
    localparam int ByteWidth    = 8;
    localparam int UnitWidth    = 16;
    localparam int PendWidth    = 3;
    localparam int PartialWidth = 31;

    // code unit constants
    localparam logic [UnitWidth-1:0] ReplChar     = 16'hFFFD;
    localparam logic [UnitWidth-1:0] HighSurrBase = 16'hD800;
    localparam logic [UnitWidth-1:0] LowSurrBase  = 16'hDC00;

    // value range limits
    localparam logic [PartialWidth-1:0] SuppBase  = 31'h0001_0000;
    localparam logic [PartialWidth-1:0] ValueLimit = 31'h0011_0000;

    // longest lead byte wants this many continuation bytes
    localparam logic [PendWidth-1:0] MaxPending = 3'd5;

    // depth of the result queue
    localparam int QueueDepth = 4;

    // one UTF-16 result as it waits in the queue
    typedef struct packed {
        logic [UnitWidth-1:0] code_unit;
        logic                 replaced;
        logic                 last_unit;
        logic                 string_ok;
    } unit_t;

endpackage

[rtl/core/u8d_byte_if.sv]
// ----------------------------------------------------------------------------
// u8d_byte_if
// Valid/ready channel that carries one UTF-8 byte and its end-of-string flag.
// ----------------------------------------------------------------------------
interface u8d_byte_if;

    logic                          valid;
    logic                          ready;
    logic [u8d_pkg::ByteWidth-1:0] byte_in;
    logic                          end_of_string;

    modport source (
        output valid,
        output byte_in,
        output end_of_string,
        input  ready
    );

    modport sink (
        input  valid,
        input  byte_in,
        input  end_of_string,
        output ready
    );

endinterface

[rtl/core/u8d_unit_if.sv]
// ----------------------------------------------------------------------------
// u8d_unit_if
// Valid/ready channel that carries one UTF-16 code unit and its status flags.
// ----------------------------------------------------------------------------
interface u8d_unit_if;

    logic                          valid;
    logic                          ready;
    logic [u8d_pkg::UnitWidth-1:0] code_unit;
    logic                          replaced;
    logic                          last_unit;
    logic                          string_ok;

    modport source (
        output valid,
        output code_unit,
        output replaced,
        output last_unit,
        output string_ok,
        input  ready
    );

    modport sink (
        input  valid,
        input  code_unit,
        input  replaced,
        input  last_unit,
        input  string_ok,
        output ready
    );

endinterface

[rtl/core/utf8_to_utf16_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Lenient UTF-8 to UTF-16 transcoder, one byte per transfer in, one code
// unit per transfer out.
// ----------------------------------------------------------------------------
// Usage:
//   utf8 takes one byte per transfer; end_of_string marks the last byte of a
//   string. utf16 gives one code unit per transfer. A byte gives zero, one or
//   two units (surrogate pair, or a replacement followed by the byte decoded
//   afresh). The last unit of a string carries last_unit and string_ok.
//   A byte's units are registered in the result queue and offered from there.
//   Throughput: one byte per cycle while the sink keeps up; the sink drains
//   one unit per cycle, so bytes that give two units can fill the queue and
//   drop ready. The byte decode is one pass of logic from the sequence state
//   into a four-entry result queue; ready is high while the queue has room
//   for two units, so a stalled sink fills the queue and then holds off the
//   source without losing anything.
//   Reset clears the sequence state, sets the string status to good and
//   empties the queue.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder (
    input  logic               clk,
    input  logic               rst_n,
    u8d_byte_if.sink           utf8,
    u8d_unit_if.source         utf16
);

    localparam int PtrWidth   = $clog2(u8d_pkg::QueueDepth);
    localparam int CountWidth = $clog2(u8d_pkg::QueueDepth + 1);
    localparam logic [CountWidth-1:0] ReadyLimit = CountWidth'(u8d_pkg::QueueDepth - 2);

    // sequence state
    logic [u8d_pkg::PendWidth-1:0]    pending_reg,   pending_next;
    logic [u8d_pkg::PartialWidth-1:0] partial_reg,   partial_next;
    logic                             all_valid_reg, all_valid_next;

    // result queue
    u8d_pkg::unit_t                   fifo_reg [u8d_pkg::QueueDepth];
    logic [PtrWidth-1:0]              wr_ptr_reg,    wr_ptr_next;
    logic [PtrWidth-1:0]              rd_ptr_reg,    rd_ptr_next;
    logic [CountWidth-1:0]            count_reg,     count_next;

    logic                             in_xfer;
    logic                             out_xfer;

    // fresh decode of the byte
    logic                             fresh_emit;
    logic                             fresh_err;
    logic [u8d_pkg::UnitWidth-1:0]    fresh_unit;
    logic [u8d_pkg::PendWidth-1:0]    fresh_pend;
    logic [u8d_pkg::PartialWidth-1:0] fresh_part;

    // per byte results
    logic [u8d_pkg::ByteWidth-1:0]    b;
    logic                             is_cont;
    logic [u8d_pkg::PartialWidth-1:0] acc;
    logic [19:0]                      supp;
    logic [u8d_pkg::PendWidth-1:0]    pend_dec;
    logic [1:0]                       n_units;
    logic                             any_err;
    u8d_pkg::unit_t                   unit0;
    u8d_pkg::unit_t                   unit1;

    assign in_xfer  = utf8.valid && utf8.ready;
    assign out_xfer = utf16.valid && utf16.ready;
    assign b        = utf8.byte_in;
    assign is_cont  = (b[7:6] == 2'b10);
    assign acc      = {partial_reg[u8d_pkg::PartialWidth-7:0], b[5:0]};
    assign supp     = acc[19:0] - u8d_pkg::SuppBase[19:0];
    assign pend_dec = pending_reg - 3'd1;

    // handshake from queue fill
    assign utf8.ready  = (count_reg <= ReadyLimit);
    assign utf16.valid = (count_reg != '0);

    assign utf16.code_unit = fifo_reg[rd_ptr_reg].code_unit;
    assign utf16.replaced  = fifo_reg[rd_ptr_reg].replaced;
    assign utf16.last_unit = fifo_reg[rd_ptr_reg].last_unit;
    assign utf16.string_ok = fifo_reg[rd_ptr_reg].string_ok;

    // byte decoded with no sequence pending
    always_comb
    begin
        fresh_emit = 1'b0;
        fresh_err  = 1'b0;
        fresh_unit = u8d_pkg::ReplChar;
        fresh_pend = '0;
        fresh_part = '0;
        case (b) inside
            [8'h00:8'h7F]:
            begin
                fresh_emit = 1'b1;
                fresh_unit = {8'd0, b};
            end
            [8'h80:8'hBF]:
            begin
                fresh_emit = 1'b1;
                fresh_err  = 1'b1;
            end
            [8'hC0:8'hDF]:
            begin
                fresh_pend = 3'd1;
                fresh_part = {26'd0, b[4:0]};
            end
            [8'hE0:8'hEF]:
            begin
                fresh_pend = 3'd2;
                fresh_part = {27'd0, b[3:0]};
            end
            [8'hF0:8'hF7]:
            begin
                fresh_pend = 3'd3;
                fresh_part = {28'd0, b[2:0]};
            end
            [8'hF8:8'hFB]:
            begin
                fresh_pend = 3'd4;
                fresh_part = {29'd0, b[1:0]};
            end
            [8'hFC:8'hFD]:
            begin
                fresh_pend = 3'd5;
                fresh_part = {30'd0, b[0]};
            end
            default:
            begin
                fresh_emit = 1'b1;
                fresh_err  = 1'b1;
            end
        endcase
    end

    // sequence step, result units and end-of-string handling
    always_comb
    begin
        n_units      = 2'd0;
        any_err      = 1'b0;
        unit0        = '{code_unit: u8d_pkg::ReplChar, replaced: 1'b1,
                         last_unit: 1'b0, string_ok: 1'b0};
        unit1        = unit0;
        pending_next = pending_reg;
        partial_next = partial_reg;

        if (pending_reg != '0 && is_cont)
        begin
            // continuation byte
            if (pend_dec == '0)
            begin
                pending_next = '0;
                partial_next = '0;
                n_units      = 2'd1;
                if (acc < u8d_pkg::SuppBase)
                begin
                    unit0.code_unit = acc[u8d_pkg::UnitWidth-1:0];
                    unit0.replaced  = 1'b0;
                end
                else if (acc >= u8d_pkg::ValueLimit)
                begin
                    any_err = 1'b1;
                end
                else
                begin
                    n_units         = 2'd2;
                    unit0.code_unit = u8d_pkg::HighSurrBase | {6'd0, supp[19:10]};
                    unit0.replaced  = 1'b0;
                    unit1.code_unit = u8d_pkg::LowSurrBase | {6'd0, supp[9:0]};
                    unit1.replaced  = 1'b0;
                end
            end
            else
            begin
                pending_next = pend_dec;
                partial_next = acc;
            end
        end
        else if (pending_reg != '0)
        begin
            // broken sequence: replacement, then the byte afresh
            any_err      = 1'b1;
            pending_next = fresh_pend;
            partial_next = fresh_part;
            if (fresh_emit)
            begin
                n_units         = 2'd2;
                unit1.code_unit = fresh_unit;
                unit1.replaced  = fresh_err;
            end
            else
            begin
                n_units = 2'd1;
            end
        end
        else
        begin
            pending_next = fresh_pend;
            partial_next = fresh_part;
            any_err      = fresh_err;
            if (fresh_emit)
            begin
                n_units         = 2'd1;
                unit0.code_unit = fresh_unit;
                unit0.replaced  = fresh_err;
            end
        end

        // truncated sequence at end of string
        if (utf8.end_of_string && pending_next != '0)
        begin
            any_err = 1'b1;
            if (n_units == 2'd1)
            begin
                n_units = 2'd2;
            end
            else if (n_units == 2'd0)
            begin
                n_units = 2'd1;
            end
        end

        all_valid_next = all_valid_reg && !any_err;

        // mark the last unit of the string
        if (utf8.end_of_string)
        begin
            if (n_units == 2'd2)
            begin
                unit1.last_unit = 1'b1;
                unit1.string_ok = all_valid_next;
            end
            else
            begin
                unit0.last_unit = 1'b1;
                unit0.string_ok = all_valid_next;
            end
            pending_next   = '0;
            partial_next   = '0;
            all_valid_next = 1'b1;
        end
    end

    // queue pointers and fill
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (in_xfer)
        begin
            wr_ptr_next = wr_ptr_reg + PtrWidth'(n_units);
            count_next  = count_next + CountWidth'(n_units);
        end
        if (out_xfer)
        begin
            rd_ptr_next = rd_ptr_reg + PtrWidth'(1);
            count_next  = count_next - CountWidth'(1);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            partial_reg   <= '0;
            all_valid_reg <= 1'b1;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                pending_reg   <= pending_next;
                partial_reg   <= partial_next;
                all_valid_reg <= all_valid_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (in_xfer && n_units != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= unit0;
        end
        if (in_xfer && n_units == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + PtrWidth'(1)] <= unit1;
        end
    end

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountWidth'(u8d_pkg::QueueDepth))
        else $error("result queue overfilled");

    // an end-of-string byte always leaves a unit to deliver
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && utf8.end_of_string |=> count_reg != '0)
        else $error("end of string produced no unit");

    // state returns to its idle values after a string ends
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && utf8.end_of_string |=> pending_reg == '0 && all_valid_reg)
        else $error("sequence state not cleared at end of string");

    // pending count stays within the longest sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= u8d_pkg::MaxPending)
        else $error("pending count out of range");

endmodule
